// File: rtl/sacl_pkg.sv
package sacl_pkg;

   localparam int unsigned ADDR_BITS   = 32;
   localparam int unsigned BLOCK_BYTES = 16;
   localparam int unsigned SETS        = 64;
   localparam int unsigned OFFSET_W    = $clog2(BLOCK_BYTES);
   localparam int unsigned SET_W       = $clog2(SETS);
   localparam int unsigned TAG_W       = ADDR_BITS - OFFSET_W - SET_W;
   localparam int unsigned STAMP_W     = 32;
   localparam int unsigned COUNT_W     = 32;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_STORE = 1'b1;

   typedef struct packed {
      logic                 command;
      logic [ADDR_BITS-1:0] address;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic               allocated;
      logic [1:0]         way_used;
      logic               evicted;
      logic [COUNT_W-1:0] load_hit_total;
      logic [COUNT_W-1:0] load_miss_total;
      logic [COUNT_W-1:0] store_hit_total;
      logic [COUNT_W-1:0] store_miss_total;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_COMPARE,
      ST_FINISH
   } state_type;

endpackage

// File: rtl/set_assoc_lru_cache_lookup.sv
// Set-associative tag store with LRU replacement. An access is taken when start is high
// and busy is low; the ways of the addressed set are then read one at a time from a single
// tag/stamp RAM, each read followed by a compare step, so an access that stops at way k
// (a hit in way k, or k = WAYS-1 on a miss) keeps busy high through a read and a compare
// step for each of ways 0 to k and then a finish step. The result strobe rsp_strobe is
// high for one cycle, the cycle in which busy drops, and the result must be taken then:
// there is no back-pressure on the response side. Valid bits sit in flip-flops and clear
// at reset, so no clearing pass is needed. csr_write_data selects write-allocate (1, reset
// value) or no-write-allocate (0) and should only be changed while busy is low.
module set_assoc_lru_cache_lookup #(
   parameter int unsigned WAYS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sacl_pkg::req_type req_data,
   output logic             rsp_strobe,
   output sacl_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic             csr_write_data
);

   localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int unsigned LINE_AW = WAY_W + sacl_pkg::SET_W;
   localparam int unsigned LINE_W  = sacl_pkg::TAG_W + sacl_pkg::STAMP_W;

   sacl_pkg::state_type state_ff, state_in;

   logic                          store_ff, store_in;
   logic [sacl_pkg::TAG_W-1:0]    tag_ff, tag_in;
   logic [sacl_pkg::SET_W-1:0]    set_ff, set_in;
   logic [WAY_W-1:0]              scan_ff, scan_in;
   logic                          hit_ff, hit_in;
   logic                          inv_found_ff, inv_found_in;
   logic [WAY_W-1:0]              inv_way_ff, inv_way_in;
   logic [WAY_W-1:0]              lru_way_ff, lru_way_in;
   logic [sacl_pkg::STAMP_W-1:0]  oldest_ff, oldest_in;

   logic [sacl_pkg::STAMP_W-1:0]  clock_ff, clock_in;
   logic [sacl_pkg::COUNT_W-1:0]  load_hit_ff, load_hit_in;
   logic [sacl_pkg::COUNT_W-1:0]  load_miss_ff, load_miss_in;
   logic [sacl_pkg::COUNT_W-1:0]  store_hit_ff, store_hit_in;
   logic [sacl_pkg::COUNT_W-1:0]  store_miss_ff, store_miss_in;

   logic                          write_allocate_ff;
   logic [sacl_pkg::SETS-1:0]     valid_ff [WAYS];

   logic                          rsp_strobe_ff, rsp_strobe_in;
   sacl_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   logic                          ram_rd_en;
   logic                          ram_wr_en;
   logic [LINE_W-1:0]             ram_rd_data;
   logic [sacl_pkg::TAG_W-1:0]    rd_tag;
   logic [sacl_pkg::STAMP_W-1:0]  rd_stamp;
   logic                          line_valid;
   logic                          alloc;
   logic [WAY_W-1:0]              victim;

   assign rd_tag   = ram_rd_data[LINE_W-1 -: sacl_pkg::TAG_W];
   assign rd_stamp = ram_rd_data[sacl_pkg::STAMP_W-1:0];

   sacl_ram #(
      .WIDTH (LINE_W),
      .DEPTH (2 ** LINE_AW)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr ({victim, set_ff}),
      .wr_data ({tag_ff, clock_ff}),
      .rd_en   (ram_rd_en),
      .rd_addr ({scan_ff, set_ff}),
      .rd_data (ram_rd_data)
   );

   // victim also carries the hit way so one write port covers stamp refresh and fill
   assign victim = hit_ff       ? scan_ff :
                   inv_found_ff ? inv_way_ff : lru_way_ff;
   assign alloc  = !hit_ff && ((store_ff == sacl_pkg::CMD_LOAD) || write_allocate_ff);

   always_comb begin
      state_in      = state_ff;
      store_in      = store_ff;
      tag_in        = tag_ff;
      set_in        = set_ff;
      scan_in       = scan_ff;
      hit_in        = hit_ff;
      inv_found_in  = inv_found_ff;
      inv_way_in    = inv_way_ff;
      lru_way_in    = lru_way_ff;
      oldest_in     = oldest_ff;
      clock_in      = clock_ff;
      load_hit_in   = load_hit_ff;
      load_miss_in  = load_miss_ff;
      store_hit_in  = store_hit_ff;
      store_miss_in = store_miss_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      ram_rd_en     = 1'b0;
      ram_wr_en     = 1'b0;
      line_valid    = valid_ff[scan_ff][set_ff];

      case (state_ff)
         sacl_pkg::ST_IDLE: begin
            if (start) begin
               store_in     = req_data.command;
               tag_in       = req_data.address[sacl_pkg::ADDR_BITS-1 -: sacl_pkg::TAG_W];
               set_in       = req_data.address[sacl_pkg::OFFSET_W +: sacl_pkg::SET_W];
               scan_in      = '0;
               hit_in       = 1'b0;
               inv_found_in = 1'b0;
               state_in     = sacl_pkg::ST_READ;
            end
         end
         sacl_pkg::ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = sacl_pkg::ST_COMPARE;
         end
         sacl_pkg::ST_COMPARE: begin
            if (line_valid && (rd_tag == tag_ff)) begin
               hit_in   = 1'b1;
               state_in = sacl_pkg::ST_FINISH;
            end else begin
               if (!line_valid && !inv_found_ff) begin
                  inv_found_in = 1'b1;
                  inv_way_in   = scan_ff;
               end
               // strict less-than keeps the lowest way on a tie
               if ((scan_ff == '0) || (rd_stamp < oldest_ff)) begin
                  oldest_in  = rd_stamp;
                  lru_way_in = scan_ff;
               end
               if (scan_ff == WAY_W'(WAYS - 1)) begin
                  state_in = sacl_pkg::ST_FINISH;
               end else begin
                  scan_in  = scan_ff + 1'b1;
                  state_in = sacl_pkg::ST_READ;
               end
            end
         end
         sacl_pkg::ST_FINISH: begin
            ram_wr_en = hit_ff || alloc;
            clock_in  = clock_ff + 1'b1;
            if (store_ff == sacl_pkg::CMD_STORE) begin
               if (hit_ff) store_hit_in  = store_hit_ff + 1'b1;
               else        store_miss_in = store_miss_ff + 1'b1;
            end else begin
               if (hit_ff) load_hit_in  = load_hit_ff + 1'b1;
               else        load_miss_in = load_miss_ff + 1'b1;
            end
            rsp_strobe_in                = 1'b1;
            rsp_data_in.hit              = hit_ff;
            rsp_data_in.allocated        = alloc;
            rsp_data_in.way_used         = (hit_ff || alloc) ? 2'(victim) : 2'd0;
            rsp_data_in.evicted          = alloc && !inv_found_ff;
            rsp_data_in.load_hit_total   = load_hit_in;
            rsp_data_in.load_miss_total  = load_miss_in;
            rsp_data_in.store_hit_total  = store_hit_in;
            rsp_data_in.store_miss_total = store_miss_in;
            state_in                     = sacl_pkg::ST_IDLE;
         end
         default: begin
            state_in = sacl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= sacl_pkg::ST_IDLE;
         clock_ff          <= '0;
         load_hit_ff       <= '0;
         load_miss_ff      <= '0;
         store_hit_ff      <= '0;
         store_miss_ff     <= '0;
         write_allocate_ff <= 1'b1;
         rsp_strobe_ff     <= 1'b0;
         for (int w = 0; w < WAYS; w++) begin
            valid_ff[w] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         clock_ff      <= clock_in;
         load_hit_ff   <= load_hit_in;
         load_miss_ff  <= load_miss_in;
         store_hit_ff  <= store_hit_in;
         store_miss_ff <= store_miss_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_write_enable) begin
            write_allocate_ff <= csr_write_data;
         end
         if (ram_wr_en) begin
            valid_ff[victim][set_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      store_ff     <= store_in;
      tag_ff       <= tag_in;
      set_ff       <= set_in;
      scan_ff      <= scan_in;
      hit_ff       <= hit_in;
      inv_found_ff <= inv_found_in;
      inv_way_ff   <= inv_way_in;
      lru_way_ff   <= lru_way_in;
      oldest_ff    <= oldest_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign busy       = (state_ff != sacl_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   a_strobe_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == sacl_pkg::ST_FINISH))
      else $error("result strobe without a finished transaction");

   a_hit_not_alloc: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> !(rsp_data_ff.hit && rsp_data_ff.allocated))
      else $error("result marked both hit and allocated");

   a_evict_needs_alloc: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_data_ff.evicted |-> rsp_data_ff.allocated)
      else $error("eviction without allocation");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   a_write_in_finish: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == sacl_pkg::ST_FINISH) && !ram_rd_en)
      else $error("line RAM written outside the finish step");

endmodule

// File: rtl/sacl_ram.sv
module sacl_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: dv/tb_set_assoc_lru_cache_lookup.sv
module tb_set_assoc_lru_cache_lookup;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned NUM_WAYS = 4;
   localparam int unsigned TIMEOUT_NS = 400_000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   sacl_pkg::req_type req_data = '0;
   logic              rsp_strobe;
   sacl_pkg::rsp_type rsp_data;
   logic              csr_write_enable = 1'b0;
   logic              csr_write_data = 1'b1;

   set_assoc_lru_cache_lookup #(
      .WAYS(NUM_WAYS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // shadow copy of the tag store
   logic                         line_valid [sacl_pkg::SETS][NUM_WAYS];
   logic [sacl_pkg::TAG_W-1:0]   line_tag   [sacl_pkg::SETS][NUM_WAYS];
   logic [sacl_pkg::STAMP_W-1:0] line_stamp [sacl_pkg::SETS][NUM_WAYS];
   logic [sacl_pkg::STAMP_W-1:0] access_clock;
   logic [sacl_pkg::COUNT_W-1:0] ld_hit_cnt, ld_miss_cnt, st_hit_cnt, st_miss_cnt;
   logic                         allocate_on_store;

   sacl_pkg::req_type pending_accesses [$];
   sacl_pkg::rsp_type expected_lookups [$];
   int                n_queued = 0;
   int                n_accepted = 0;
   int                n_errors = 0;
   int                sender_gap_max = 3;
   int                gap_left = 0;
   logic              holding;
   sacl_pkg::rsp_type want;

   function automatic sacl_pkg::rsp_type predict_lookup(input sacl_pkg::req_type r);
      logic [sacl_pkg::SET_W-1:0]   set_idx;
      logic [sacl_pkg::TAG_W-1:0]   tag;
      logic [sacl_pkg::STAMP_W-1:0] oldest;
      logic                         found;
      int                           way;
      int                           w;
      sacl_pkg::rsp_type            p;
      set_idx = r.address[sacl_pkg::OFFSET_W +: sacl_pkg::SET_W];
      tag     = r.address[sacl_pkg::ADDR_BITS-1 -: sacl_pkg::TAG_W];
      p       = '0;
      way     = 0;
      for (w = 0; w < NUM_WAYS; w++) begin
         if (!p.hit && line_valid[set_idx][w] && line_tag[set_idx][w] == tag) begin
            p.hit = 1'b1;
            way   = w;
         end
      end
      if (p.hit) begin
         line_stamp[set_idx][way] = access_clock;
         if (r.command == sacl_pkg::CMD_STORE) st_hit_cnt++;
         else ld_hit_cnt++;
      end else begin
         if (r.command == sacl_pkg::CMD_STORE) st_miss_cnt++;
         else ld_miss_cnt++;
         if (r.command == sacl_pkg::CMD_LOAD || allocate_on_store) begin
            found = 1'b0;
            for (w = 0; w < NUM_WAYS; w++) begin
               if (!found && !line_valid[set_idx][w]) begin
                  found = 1'b1;
                  way   = w;
               end
            end
            if (!found) begin
               // LRU victim: smallest stamp, lowest way on a tie
               oldest = line_stamp[set_idx][0];
               way    = 0;
               for (w = 1; w < NUM_WAYS; w++) begin
                  if (line_stamp[set_idx][w] < oldest) begin
                     oldest = line_stamp[set_idx][w];
                     way    = w;
                  end
               end
               p.evicted = 1'b1;
            end
            p.allocated = 1'b1;
            line_valid[set_idx][way] = 1'b1;
            line_tag[set_idx][way]   = tag;
            line_stamp[set_idx][way] = access_clock;
         end
      end
      access_clock = access_clock + 1'b1;
      if (p.hit || p.allocated) p.way_used = 2'(way);
      p.load_hit_total   = ld_hit_cnt;
      p.load_miss_total  = ld_miss_cnt;
      p.store_hit_total  = st_hit_cnt;
      p.store_miss_total = st_miss_cnt;
      return p;
   endfunction

   // driver: one start per transaction, random gap before the next one
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         gap_left = 0;
      end else begin
         holding = start && busy;
         if (start && !busy) begin
            expected_lookups.push_back(predict_lookup(req_data));
            n_accepted++;
            gap_left = $urandom_range(sender_gap_max, 0);
         end
         if (!holding) begin
            if (gap_left == 0 && pending_accesses.size() != 0) begin
               req_data <= pending_accesses.pop_front();
               start    <= 1'b1;
            end else begin
               start <= 1'b0;
               if (gap_left > 0) gap_left--;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_lookups.size() == 0) begin
            n_errors++;
            if (n_errors <= 10) $display("ERROR: result with no access outstanding");
         end else begin
            want = expected_lookups.pop_front();
            if (rsp_data !== want) begin
               n_errors++;
               if (n_errors <= 10) begin
                  $display("ERROR: exp hit=%b alloc=%b way=%0d evict=%b totals=%0d/%0d/%0d/%0d",
                           want.hit, want.allocated, want.way_used, want.evicted,
                           want.load_hit_total, want.load_miss_total,
                           want.store_hit_total, want.store_miss_total);
                  $display("       got hit=%b alloc=%b way=%0d evict=%b totals=%0d/%0d/%0d/%0d",
                           rsp_data.hit, rsp_data.allocated, rsp_data.way_used,
                           rsp_data.evicted, rsp_data.load_hit_total,
                           rsp_data.load_miss_total, rsp_data.store_hit_total,
                           rsp_data.store_miss_total);
               end
            end
         end
      end
   end

   task automatic queue_access(input logic cmd, input logic [sacl_pkg::TAG_W-1:0] tag,
                               input logic [sacl_pkg::SET_W-1:0] set_idx,
                               input logic [sacl_pkg::OFFSET_W-1:0] offset);
      sacl_pkg::req_type r;
      r.command = cmd;
      r.address = {tag, set_idx, offset};
      pending_accesses.push_back(r);
      n_queued++;
   endtask

   task automatic drain();
      while (n_accepted != n_queued || expected_lookups.size() != 0) @(posedge clock);
   endtask

   task automatic write_policy(input logic value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      allocate_on_store = value;
   endtask

   task automatic random_phase(input int count, input int gap_max, input logic policy);
      logic [sacl_pkg::TAG_W-1:0] tag_pool [6];
      logic [sacl_pkg::SET_W-1:0] set_pool [3];
      int                         i;
      write_policy(policy);
      sender_gap_max = gap_max;
      for (i = 0; i < 6; i++) tag_pool[i] = sacl_pkg::TAG_W'($urandom);
      for (i = 0; i < 3; i++) set_pool[i] = sacl_pkg::SET_W'($urandom);
      for (i = 0; i < count; i++) begin
         // mostly a few hot sets with a small tag pool so hits and evictions happen
         if ($urandom_range(9, 0) < 8)
            queue_access($urandom_range(1, 0) ? sacl_pkg::CMD_STORE : sacl_pkg::CMD_LOAD,
                         tag_pool[$urandom_range(5, 0)], set_pool[$urandom_range(2, 0)],
                         sacl_pkg::OFFSET_W'($urandom));
         else
            queue_access($urandom_range(1, 0) ? sacl_pkg::CMD_STORE : sacl_pkg::CMD_LOAD,
                         sacl_pkg::TAG_W'($urandom), sacl_pkg::SET_W'($urandom),
                         sacl_pkg::OFFSET_W'($urandom));
      end
      drain();
   endtask

   initial begin
      for (int s = 0; s < sacl_pkg::SETS; s++) begin
         for (int w = 0; w < NUM_WAYS; w++) begin
            line_valid[s][w] = 1'b0;
            line_tag[s][w]   = '0;
            line_stamp[s][w] = '0;
         end
      end
      access_clock      = '0;
      ld_hit_cnt        = '0;
      ld_miss_cnt       = '0;
      st_hit_cnt        = '0;
      st_miss_cnt       = '0;
      allocate_on_store = 1'b1;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      write_policy(1'b1);
      queue_access(sacl_pkg::CMD_LOAD,  '0, '0, '0);
      queue_access(sacl_pkg::CMD_LOAD,  '0, '0, '1);
      queue_access(sacl_pkg::CMD_STORE, '0, '0, '0);
      queue_access(sacl_pkg::CMD_LOAD,  '1, '1, '1);
      queue_access(sacl_pkg::CMD_STORE, '1, '1, '0);
      // fill one set, refresh way 0, then force LRU replacements
      queue_access(sacl_pkg::CMD_LOAD,  22'h2AAAAA, 6'd5, 4'h3);
      queue_access(sacl_pkg::CMD_LOAD,  22'h155555, 6'd5, 4'hC);
      queue_access(sacl_pkg::CMD_LOAD,  22'h000001, 6'd5, 4'h0);
      queue_access(sacl_pkg::CMD_LOAD,  22'h200000, 6'd5, 4'hF);
      queue_access(sacl_pkg::CMD_LOAD,  22'h2AAAAA, 6'd5, 4'h8);
      queue_access(sacl_pkg::CMD_LOAD,  22'h0F0F0F, 6'd5, 4'h1);
      queue_access(sacl_pkg::CMD_STORE, 22'h30F0F0, 6'd5, 4'h2);
      queue_access(sacl_pkg::CMD_LOAD,  22'h155555, 6'd5, 4'h4);
      drain();

      // no-write-allocate: store misses leave the set alone
      write_policy(1'b0);
      queue_access(sacl_pkg::CMD_STORE, 22'h123456, 6'd9, 4'h7);
      queue_access(sacl_pkg::CMD_LOAD,  22'h123456, 6'd9, 4'h7);
      queue_access(sacl_pkg::CMD_STORE, 22'h123456, 6'd9, 4'hA);
      queue_access(sacl_pkg::CMD_STORE, 22'h3ABCDE, 6'd5, 4'h5);
      queue_access(sacl_pkg::CMD_LOAD,  22'h3ABCDE, 6'd5, 4'h5);
      drain();

      random_phase(125, 3, 1'b1);
      random_phase(125, 0, 1'b0);
      random_phase(125, 3, 1'b1);
      random_phase(125, 3, 1'b0);
      random_phase(125, 0, 1'b1);
      random_phase(125, 3, 1'b0);

      repeat (20) @(posedge clock);
      if (n_errors == 0 && expected_lookups.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS * 1ns);
      $display("ERROR: timeout");
      $display("TEST FAILED");
      $finish;
   end

endmodule

// File: sim.f
rtl/sacl_pkg.sv
rtl/sacl_ram.sv
rtl/set_assoc_lru_cache_lookup.sv
dv/tb_set_assoc_lru_cache_lookup.sv
